### rtl/hta_pkg.sv
// Shared types and constants for the handle table allocator.
// No dependencies; used by hta_table and handle_table_allocator_unit.
package hta_pkg;

    // Default table size
    localparam int MAX_HANDLES_DEF = 64;

    // Flag byte layout: owned mark, free mark, 6-bit type
    localparam logic [7:0] FLAG_OWNED = 8'h80;
    localparam logic [7:0] FLAG_FREE  = 8'h40;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_LOOKUP  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_INVALID = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Table write request: entry index is a zero-based 7-bit index
    typedef struct packed {
        logic        en;
        logic [6:0]  idx;
        logic [7:0]  flags;
        logic [31:0] word;
    } t_tbl_wr;

endpackage

### rtl/handle_table_allocator_unit.sv
// Top level of the handle table allocator: control, free list and result register.
// Depends on hta_pkg and hta_table.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request beat: op,
//   handle, object word, owned mark, type and ignore-type flag. Output channel
//   (o_out_valid / i_out_ready) returns one result beat per request: status,
//   allocated handle, object word, free-buffer mark and stored type.
//   On accept the block issues the table read (free-list head for allocate,
//   addressed entry for release and lookup) and enters execute; execute checks
//   the entry, writes the table and loads the result register. Because of the
//   single table read port and the free-list link that allocate must fetch
//   before the next pop, a new request is taken only after the previous one
//   has left execute.
//   A waiting result does not block acceptance of the next request; that
//   request then holds in execute until the result register is taken, and
//   o_in_ready stays low meanwhile.
//   Reset empties the free list and clears the high-water mark; table
//   contents are not cleared and need no clearing pass, since only entries
//   below the high-water mark are ever used.
module handle_table_allocator_unit #(
    parameter int MAX_HANDLES = hta_pkg::MAX_HANDLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [6:0]  i_handle_in,
    input  logic [31:0] i_object_word,
    input  logic        i_owns_buffer,
    input  logic [5:0]  i_type_code,
    input  logic        i_ignore_type,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_handle_out,
    output logic [31:0] o_object_out,
    output logic        o_free_buffer,
    output logic [5:0]  o_type_out
);

    // Handle numbers are 7 bits, so at most 127 entries are usable
    localparam int         CAPACITY = (MAX_HANDLES < 127) ? MAX_HANDLES : 127;
    localparam logic [6:0] CAP7     = 7'(CAPACITY);

    hta_pkg::t_state r_state, n_state;

    logic        in_accept;
    logic        load_out;
    logic        rd_en;
    logic [6:0]  rd_idx;
    logic [7:0]  rd_flags;
    logic [31:0] rd_word;

    // Request register
    logic [1:0]  r_op;
    logic [6:0]  r_handle;
    logic [31:0] r_obj;
    logic        r_owns;
    logic [5:0]  r_type;
    logic        r_ign;

    // Allocator state
    logic [6:0]  r_free_head, n_free_head;
    logic [6:0]  r_high_water, n_high_water;

    // Result register
    logic        r_out_valid;
    logic [1:0]  r_status, n_status;
    logic [6:0]  r_handle_out, n_handle_out;
    logic [31:0] r_object_out, n_object_out;
    logic        r_free_buffer, n_free_buffer;
    logic [5:0]  r_type_out, n_type_out;

    hta_pkg::t_tbl_wr wr_req;
    hta_pkg::t_tbl_wr tbl_wr;

    logic        handle_ok;
    logic        pop_ok;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hta_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = hta_pkg::S_EXEC;
                end
            end
            hta_pkg::S_EXEC: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = hta_pkg::S_IDLE;
                end
            end
            default: n_state = hta_pkg::S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            hta_pkg::S_IDLE: o_in_ready = 1'b1;
            hta_pkg::S_EXEC: load_out   = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                load_out   = 1'b0;
            end
        endcase
    end

    assign in_accept = i_in_valid && o_in_ready;

    // Table read address: free-list head for allocate, else the given handle
    assign rd_en  = in_accept;
    assign rd_idx = (i_op == hta_pkg::OP_ALLOC) ? (r_free_head - 7'd1) : (i_handle_in - 7'd1);

    hta_table #(
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_idx   (rd_idx),
        .i_wr       (tbl_wr),
        .o_rd_flags (rd_flags),
        .o_rd_word  (rd_word)
    );

    // Entry checks
    assign pop_ok    = (r_free_head != 7'd0) && (r_free_head <= CAP7);
    assign handle_ok = (r_handle != 7'd0) && (r_handle <= r_high_water) &&
                       (r_handle <= CAP7) && (rd_flags != hta_pkg::FLAG_FREE);

    // Execute the request against the entry read back
    always_comb begin
        n_status      = hta_pkg::STS_INVALID;
        n_handle_out  = 7'd0;
        n_object_out  = 32'd0;
        n_free_buffer = 1'b0;
        n_type_out    = 6'd0;
        n_free_head   = r_free_head;
        n_high_water  = r_high_water;
        wr_req        = '0;
        case (r_op)
            hta_pkg::OP_ALLOC: begin
                wr_req.flags = (r_owns ? hta_pkg::FLAG_OWNED : 8'h00) | {2'b00, r_type};
                wr_req.word  = r_obj;
                if (pop_ok) begin
                    wr_req.en    = 1'b1;
                    wr_req.idx   = r_free_head - 7'd1;
                    n_free_head  = rd_word[6:0];
                    n_status     = hta_pkg::STS_OK;
                    n_handle_out = r_free_head;
                end else if (r_high_water < CAP7) begin
                    wr_req.en    = 1'b1;
                    wr_req.idx   = r_high_water;
                    n_high_water = r_high_water + 7'd1;
                    n_status     = hta_pkg::STS_OK;
                    n_handle_out = r_high_water + 7'd1;
                end else begin
                    n_status = hta_pkg::STS_FULL;
                end
            end
            hta_pkg::OP_RELEASE: begin
                if (handle_ok) begin
                    wr_req.en     = 1'b1;
                    wr_req.idx    = r_handle - 7'd1;
                    wr_req.flags  = hta_pkg::FLAG_FREE;
                    wr_req.word   = {25'd0, r_free_head};
                    n_free_head   = r_handle;
                    n_status      = hta_pkg::STS_OK;
                    n_free_buffer = (rd_flags & hta_pkg::FLAG_OWNED) != 8'h00;
                    n_object_out  = n_free_buffer ? rd_word : 32'd0;
                end
            end
            hta_pkg::OP_LOOKUP: begin
                if (handle_ok && (r_ign || (rd_flags[5:0] == r_type))) begin
                    n_status     = hta_pkg::STS_OK;
                    n_object_out = rd_word;
                    n_type_out   = rd_flags[5:0];
                end
            end
            default: begin
                n_status = hta_pkg::STS_INVALID;
            end
        endcase
    end

    // Commit the table write only when the result is loaded
    always_comb begin
        tbl_wr    = wr_req;
        tbl_wr.en = wr_req.en && load_out;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hta_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_free_head  <= 7'd0;
            r_high_water <= 7'd0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid  <= 1'b1;
                r_free_head  <= n_free_head;
                r_high_water <= n_high_water;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op     <= i_op;
            r_handle <= i_handle_in;
            r_obj    <= i_object_word;
            r_owns   <= i_owns_buffer;
            r_type   <= i_type_code;
            r_ign    <= i_ignore_type;
        end
    end

    // Load the result beat
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status      <= n_status;
            r_handle_out  <= n_handle_out;
            r_object_out  <= n_object_out;
            r_free_buffer <= n_free_buffer;
            r_type_out    <= n_type_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_handle_out  = r_handle_out;
    assign o_object_out  = r_object_out;
    assign o_free_buffer = r_free_buffer;
    assign o_type_out    = r_type_out;

    // High-water mark never passes the usable capacity
    a_hw_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_water <= CAP7)
        else $error("high-water mark beyond capacity");

    // Free-list head always points at an entry already taken
    a_head_below_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_head <= r_high_water)
        else $error("free-list head above high-water mark");

    // An accepted beat goes straight to execute
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == hta_pkg::S_EXEC))
        else $error("accepted beat did not enter execute");

    // A returned handle refers to an entry below the high-water mark
    a_handle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_handle_out != 7'd0)) |-> (o_handle_out <= r_high_water))
        else $error("returned handle above high-water mark");

    // Loading a result frees the input side on the next cycle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (o_in_ready && o_out_valid))
        else $error("result load did not return to idle");

endmodule

### rtl/hta_table.sv
// Entry storage for the handle table: flag byte and object word per entry.
// One registered read port and one write port. Depends on hta_pkg.
module hta_table #(
    parameter int DEPTH = hta_pkg::MAX_HANDLES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [6:0]       i_rd_idx,
    input  hta_pkg::t_tbl_wr i_wr,
    output logic [7:0]       o_rd_flags,
    output logic [31:0]      o_rd_word
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]  r_flags [DEPTH];
    logic [31:0] r_word  [DEPTH];
    logic [7:0]  r_rd_flags;
    logic [31:0] r_rd_word;

    // Write one entry per beat
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_flags[i_wr.idx[AW-1:0]] <= i_wr.flags;
            r_word[i_wr.idx[AW-1:0]]  <= i_wr.word;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_flags <= r_flags[i_rd_idx[AW-1:0]];
            r_rd_word  <= r_word[i_rd_idx[AW-1:0]];
        end
    end

    assign o_rd_flags = r_rd_flags;
    assign o_rd_word  = r_rd_word;

endmodule

### tb/handle_table_allocator_unit_checker.sv
// Checker for the handle table allocator: watches both channels, predicts each result beat
// and compares it field by field. Depends on hta_pkg for op and status codes.
module handle_table_allocator_unit_checker
    import hta_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_op,
    input  logic [6:0]  i_handle_in,
    input  logic [31:0] i_object_word,
    input  logic        i_owns_buffer,
    input  logic [5:0]  i_type_code,
    input  logic        i_ignore_type,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [6:0]  i_handle_out,
    input  logic [31:0] i_object_out,
    input  logic        i_free_buffer,
    input  logic [5:0]  i_type_out,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_CAP  = (MAX_HANDLES_DEF < 127) ? MAX_HANDLES_DEF : 127;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        t_status     status;
        logic [6:0]  handle;
        logic [31:0] obj;
        logic        free_buf;
        logic [5:0]  ty;
    } t_outcome;

    // Shadow of the handle table and its free list
    logic [7:0]  entry_tag [MAX_HANDLES_DEF];
    logic [31:0] entry_obj [MAX_HANDLES_DEF];
    int          free_top;
    int          next_fresh;
    t_outcome    outcome_q [$];

    // A handle is usable when in range, below the high-water mark and not on the free list
    function automatic bit entry_in_use(input logic [6:0] h);
        if (h == 0 || h > next_fresh || h > TABLE_CAP)
            return 1'b0;
        return entry_tag[h - 1] != FLAG_FREE;
    endfunction

    // Apply one request to the shadow table and return the result it must produce
    function automatic t_outcome predict_outcome(input logic [1:0] op, input logic [6:0] h,
                                                 input logic [31:0] obj, input logic owns,
                                                 input logic [5:0] ty, input logic ign);
        t_outcome res;
        int       slot;
        logic     owned;
        res        = '0;
        res.status = STS_OK;
        case (op)
            OP_ALLOC: begin
                slot = -1;
                if (free_top != 0 && free_top <= TABLE_CAP) begin
                    slot     = free_top - 1;
                    free_top = int'(entry_obj[slot][6:0]);
                end else if (next_fresh < TABLE_CAP) begin
                    slot       = next_fresh;
                    next_fresh = next_fresh + 1;
                end
                if (slot < 0) begin
                    res.status = STS_FULL;
                end else begin
                    entry_tag[slot] = (owns ? FLAG_OWNED : 8'h00) | {2'b00, ty};
                    entry_obj[slot] = obj;
                    res.handle      = 7'(slot + 1);
                end
            end
            OP_RELEASE: begin
                if (!entry_in_use(h)) begin
                    res.status = STS_INVALID;
                end else begin
                    slot            = int'(h) - 1;
                    owned           = (entry_tag[slot] & FLAG_OWNED) != 0;
                    res.obj         = owned ? entry_obj[slot] : 32'h0;
                    res.free_buf    = owned;
                    entry_tag[slot] = FLAG_FREE;
                    entry_obj[slot] = 32'(free_top);
                    free_top        = slot + 1;
                end
            end
            OP_LOOKUP: begin
                if (entry_in_use(h) && (ign || entry_tag[h - 1][5:0] == ty)) begin
                    res.obj = entry_obj[h - 1];
                    res.ty  = entry_tag[h - 1][5:0];
                end else begin
                    res.status = STS_INVALID;
                end
            end
            default: res.status = STS_INVALID;
        endcase
        return res;
    endfunction

    task automatic note_fault(input string what);
        o_errors = o_errors + 1;
        if (o_errors <= REPORT_MAX)
            $display("%s", what);
    endtask

    // Compare result beats first, then predict for the request beat taken at the same edge
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_HANDLES_DEF; i++) begin
                entry_tag[i] = 8'h00;
                entry_obj[i] = 32'h0;
            end
            free_top   = 0;
            next_fresh = 0;
            outcome_q.delete();
            o_errors   = 0;
            o_checked  = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_checked = o_checked + 1;
                if (outcome_q.size() == 0) begin
                    note_fault($sformatf("unexpected result beat: status=%0d handle=%0d obj=%h",
                                         i_status, i_handle_out, i_object_out));
                end else begin
                    want = outcome_q.pop_front();
                    if (i_status !== want.status || i_handle_out !== want.handle ||
                        i_object_out !== want.obj || i_free_buffer !== want.free_buf ||
                        i_type_out !== want.ty)
                        note_fault($sformatf({"result %0d mismatch: expected status=%0d ",
                            "handle=%0d obj=%h free=%0b type=%0d, got status=%0d handle=%0d ",
                            "obj=%h free=%0b type=%0d"}, o_checked, want.status, want.handle,
                            want.obj, want.free_buf, want.ty, i_status, i_handle_out,
                            i_object_out, i_free_buffer, i_type_out));
                end
            end
            if (i_in_valid && i_in_ready)
                outcome_q.push_back(predict_outcome(i_op, i_handle_in, i_object_word,
                                                    i_owns_buffer, i_type_code, i_ignore_type));
        end
        o_pending = outcome_q.size();
    end

endmodule

### tb/handle_table_allocator_unit_tb.sv
// Top of the handle table allocator testbench: clock, reset, request and result traffic,
// watchdog and verdict. Depends on hta_pkg, the block and handle_table_allocator_unit_checker.
module handle_table_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hta_pkg::*;

    localparam logic [1:0] OP_UNDEF    = 2'd3;
    localparam int TABLE_CAP        = (MAX_HANDLES_DEF < 127) ? MAX_HANDLES_DEF : 127;
    localparam int ITEMS_PER_PHASE  = 170;
    localparam int CHUNK_ITEMS      = 60;
    localparam int STALL_HOLD       = 80;
    localparam int DRAIN_CYCLES     = 10;
    localparam int WATCHDOG_LIMIT   = 4000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  req_op;
    logic [6:0]  req_handle;
    logic [31:0] req_obj;
    logic        req_owns;
    logic [5:0]  req_type;
    logic        req_ign;
    logic        rsp_valid;
    logic        rsp_ready;
    logic [1:0]  rsp_status;
    logic [6:0]  rsp_handle;
    logic [31:0] rsp_obj;
    logic        rsp_free;
    logic [5:0]  rsp_type;

    int errors;
    int pending;
    int checked;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    // Stimulus-side view of which handles are live, used to aim requests at real entries
    int         live_q [$];
    logic [5:0] live_ty [1:TABLE_CAP];
    int         free_q [$];
    int         fresh_top;
    int         full_seen;
    int         op_sent [4];

    handle_table_allocator_unit i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (req_valid),
        .o_in_ready    (req_ready),
        .i_op          (req_op),
        .i_handle_in   (req_handle),
        .i_object_word (req_obj),
        .i_owns_buffer (req_owns),
        .i_type_code   (req_type),
        .i_ignore_type (req_ign),
        .o_out_valid   (rsp_valid),
        .i_out_ready   (rsp_ready),
        .o_status      (rsp_status),
        .o_handle_out  (rsp_handle),
        .o_object_out  (rsp_obj),
        .o_free_buffer (rsp_free),
        .o_type_out    (rsp_type)
    );

    handle_table_allocator_unit_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (req_valid),
        .i_in_ready    (req_ready),
        .i_op          (req_op),
        .i_handle_in   (req_handle),
        .i_object_word (req_obj),
        .i_owns_buffer (req_owns),
        .i_type_code   (req_type),
        .i_ignore_type (req_ign),
        .i_out_valid   (rsp_valid),
        .i_out_ready   (rsp_ready),
        .i_status      (rsp_status),
        .i_handle_out  (rsp_handle),
        .i_object_out  (rsp_obj),
        .i_free_buffer (rsp_free),
        .i_type_out    (rsp_type),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int live_pos(input int h);
        for (int i = 0; i < live_q.size(); i++)
            if (live_q[i] == h)
                return i;
        return -1;
    endfunction

    // Track the live set, then present one request beat and hold it until taken
    task automatic issue(input logic [1:0] op, input logic [6:0] h, input logic [31:0] obj,
                         input logic owns, input logic [5:0] ty, input logic ign);
        int slot;
        int pos;
        op_sent[op] = op_sent[op] + 1;
        if (op == OP_ALLOC) begin
            slot = 0;
            if (free_q.size() > 0) begin
                slot = free_q.pop_front();
            end else if (fresh_top < TABLE_CAP) begin
                fresh_top = fresh_top + 1;
                slot      = fresh_top;
            end
            if (slot == 0) begin
                full_seen = full_seen + 1;
            end else begin
                live_q.push_back(slot);
                live_ty[slot] = ty;
            end
        end else if (op == OP_RELEASE) begin
            pos = live_pos(int'(h));
            if (pos >= 0) begin
                live_q.delete(pos);
                free_q.push_front(int'(h));
            end
        end
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid  <= 1'b1;
        req_op     <= op;
        req_handle <= h;
        req_obj    <= obj;
        req_owns   <= owns;
        req_type   <= ty;
        req_ign    <= ign;
        do @(posedge clk); while (!req_ready);
    endtask

    // Mostly well-formed traffic on live handles, with some noise on arbitrary handles
    task automatic random_item(input int alloc_pct);
        logic [1:0] noise_ops [4];
        int         sel;
        int         h;
        logic [5:0] ty;
        noise_ops = '{OP_ALLOC, OP_RELEASE, OP_LOOKUP, OP_UNDEF};
        sel = $urandom_range(99);
        if ($urandom_range(99) < alloc_pct) begin
            issue(OP_ALLOC, 7'($urandom_range(64)), $urandom, 1'($urandom_range(1)),
                  6'($urandom_range(63)), 1'($urandom_range(1)));
        end else if (live_q.size() == 0 || sel >= 85) begin
            issue(noise_ops[($urandom_range(9) == 0) ? 3 : $urandom_range(2)],
                  7'($urandom_range(64)), $urandom, 1'($urandom_range(1)),
                  6'($urandom_range(63)), 1'($urandom_range(1)));
        end else begin
            h = live_q[$urandom_range(live_q.size() - 1)];
            if (sel < 35) begin
                issue(OP_RELEASE, 7'(h), $urandom, 1'($urandom_range(1)),
                      6'($urandom_range(63)), 1'($urandom_range(1)));
            end else begin
                ty = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : live_ty[h];
                issue(OP_LOOKUP, 7'(h), $urandom, 1'($urandom_range(1)), ty,
                      1'($urandom_range(3) == 0));
            end
        end
    endtask

    // Result side: a long hold-off when requested, otherwise random stalls
    initial begin
        rsp_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                rsp_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: end the run when neither channel moves a beat for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int send_pcts [4];
        int recv_pcts [4];
        int alloc_pct;
        send_pcts      = '{0, 48, 0, 26};
        recv_pcts      = '{0, 0, 48, 26};
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_op         = OP_ALLOC;
        req_handle     = 7'd0;
        req_obj        = 32'h0;
        req_owns       = 1'b0;
        req_type       = 6'd0;
        req_ign        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        fresh_top      = 0;
        full_seen      = 0;
        op_sent        = '{0, 0, 0, 0};
        alloc_pct      = 50;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, type check and ignore, bad handles, double release, reuse order
        issue(OP_ALLOC,   7'd0,  32'h0000_0000, 1'b0, 6'd0,  1'b0);
        issue(OP_ALLOC,   7'd0,  32'hFFFF_FFFF, 1'b1, 6'd63, 1'b0);
        issue(OP_ALLOC,   7'd0,  32'h0000_0000, 1'b1, 6'd21, 1'b0);
        issue(OP_LOOKUP,  7'd1,  32'h0,         1'b0, 6'd0,  1'b0);
        issue(OP_LOOKUP,  7'd2,  32'h0,         1'b0, 6'd63, 1'b0);
        issue(OP_LOOKUP,  7'd2,  32'h0,         1'b0, 6'd0,  1'b0);
        issue(OP_LOOKUP,  7'd2,  32'h0,         1'b0, 6'd0,  1'b1);
        issue(OP_LOOKUP,  7'd0,  32'h0,         1'b0, 6'd0,  1'b1);
        issue(OP_LOOKUP,  7'd64, 32'h0,         1'b0, 6'd0,  1'b1);
        issue(OP_RELEASE, 7'd0,  32'h0,         1'b0, 6'd0,  1'b0);
        issue(OP_RELEASE, 7'd64, 32'h0,         1'b0, 6'd0,  1'b0);
        issue(OP_RELEASE, 7'd2,  32'h0,         1'b0, 6'd0,  1'b0);
        issue(OP_RELEASE, 7'd3,  32'h0,         1'b0, 6'd0,  1'b0);
        issue(OP_RELEASE, 7'd2,  32'h0,         1'b0, 6'd0,  1'b0);
        issue(OP_LOOKUP,  7'd2,  32'h0,         1'b0, 6'd63, 1'b1);
        issue(OP_RELEASE, 7'd1,  32'h0,         1'b0, 6'd0,  1'b0);
        issue(OP_UNDEF,   7'd64, 32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1);
        issue(OP_ALLOC,   7'd0,  32'hA5A5_A5A5, 1'b0, 6'd42, 1'b0);
        issue(OP_ALLOC,   7'd0,  32'h5A5A_5A5A, 1'b1, 6'd1,  1'b0);
        issue(OP_ALLOC,   7'd0,  32'h8000_0001, 1'b0, 6'd32, 1'b0);
        issue(OP_ALLOC,   7'd0,  32'h0000_FFFF, 1'b1, 6'd7,  1'b0);
        issue(OP_LOOKUP,  7'd4,  32'h0,         1'b0, 6'd7,  1'b0);

        // Random phases with different idling; the first favours allocate and stalls results
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_pcts[phase];
            recv_stall_pct = recv_pcts[phase];
            if (phase == 0)
                hold_left = STALL_HOLD;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % CHUNK_ITEMS == 0) begin
                    if (phase == 0 && n == 0)
                        alloc_pct = 95;
                    else
                        case ($urandom_range(2))
                            0:       alloc_pct = 10;
                            1:       alloc_pct = 50;
                            default: alloc_pct = 90;
                        endcase
                end
                random_item(alloc_pct);
            end
        end

        // Drain outstanding results, then idle with no request to catch stray beats
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d allocate, %0d release, %0d lookup and %0d unknown-op requests",
                 op_sent[OP_ALLOC], op_sent[OP_RELEASE], op_sent[OP_LOOKUP], op_sent[OP_UNDEF]);
        $display("over four idling patterns; %0d hit a full table, %0d results checked",
                 full_seen, checked);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### files.f
rtl/hta_pkg.sv
rtl/hta_table.sv
rtl/handle_table_allocator_unit.sv
tb/handle_table_allocator_unit_checker.sv
tb/handle_table_allocator_unit_tb.sv
